>>> src/bmd_pkg.sv
// ----------------------------------------------------------------------------
// Bus message deserializer package
// Types, codes and schedule helpers shared by the deserializer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bmd_pkg;

  localparam int VAL_W  = 61;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] KNOWN_LOW       = 8'hF5;
  localparam logic [7:0] HEAD_VALUE_MASK = 8'h1F;

  localparam logic [3:0] KIND_USER        = 4'd0;
  localparam logic [3:0] KIND_MESSAGE     = 4'd1;
  localparam logic [3:0] KIND_REPLACE     = 4'd2;
  localparam logic [3:0] KIND_ERASE       = 4'd4;
  localparam logic [3:0] KIND_NOROUTE     = 4'd6;
  localparam logic [3:0] KIND_ADD_GROUP   = 4'd7;
  localparam logic [3:0] KIND_CLOSE_GROUP = 4'd8;
  localparam logic [3:0] KIND_NEW_SESSION = 4'd10;
  localparam logic [3:0] KIND_SERIAL      = 4'd11;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_NUM_HEAD,
    PH_NUM_EXTRA,
    PH_STR,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    EV_TYPE,
    EV_UINT,
    EV_STR_HDR,
    EV_STR_BYTE,
    EV_PAYLOAD,
    EV_END,
    EV_EMPTY
  } event_t;

  typedef struct packed {
    event_t             ev;
    logic [3:0]         msg_kind;
    logic [7:0]         type_byte;
    logic [1:0]         field_pos;
    logic [VAL_W-1:0]   list_index;
    logic [VAL_W-1:0]   value;
    logic [7:0]         data_out;
    logic               truncated;
    logic               run_last;
  } res_t;

  function automatic logic is_list(input logic [3:0] k);
    return (k >= KIND_REPLACE) && (k <= KIND_ERASE);
  endfunction

  function automatic logic [2:0] field_count(input logic [3:0] k);
    logic [2:0] fc;
    fc = 3'd0;
    if (k == KIND_MESSAGE) fc = 3'd4;
    else if (is_list(k)) fc = 3'd2;
    else if ((k == KIND_NOROUTE) || (k == KIND_ADD_GROUP)) fc = 3'd2;
    else if ((k >= KIND_CLOSE_GROUP) && (k <= KIND_SERIAL)) fc = 3'd1;
    return fc;
  endfunction

  function automatic logic field_is_string(input logic [3:0] k, input logic [1:0] pos);
    logic s;
    if (k == KIND_MESSAGE) s = (pos != 2'd0);
    else if (is_list(k)) s = (pos == 2'd1);
    else s = (k != KIND_NEW_SESSION);
    return s;
  endfunction

  function automatic phase_t enter_phase(input logic [3:0] k, input logic [1:0] pos,
                                         input logic [VAL_W-1:0] list_left);
    phase_t p;
    if (field_count(k) == 3'd0) p = PH_DONE;
    else if (is_list(k) && (pos == 2'd1) && (list_left == '0)) p = PH_DONE;
    else p = PH_NUM_HEAD;
    return p;
  endfunction

  function automatic res_t make_res(input event_t ev, input logic [3:0] k,
                                    input logic [7:0] tb, input logic [1:0] pos,
                                    input logic [VAL_W-1:0] lidx,
                                    input logic [VAL_W-1:0] val,
                                    input logic [7:0] dout, input logic trunc);
    res_t r;
    r.ev         = ev;
    r.msg_kind   = (ev == EV_EMPTY) ? 4'd0 : k;
    r.type_byte  = (ev == EV_EMPTY) ? 8'd0 : tb;
    r.field_pos  = pos;
    r.list_index = lidx;
    r.value      = val;
    r.data_out   = dout;
    r.truncated  = trunc;
    r.run_last   = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/bus_message_deserializer.sv
// Each accepted byte is registered in the input stage, then decoded into the result queue that drives the outputs.
// Throughput: one byte per cycle while the result queue has room; the result port moves one
// record per cycle, so a final byte with two results (a record and the end) sends them one after the other.
// The four-entry result queue sets how far the output may stall before input stalls.
// Reset: synchronous, active low; message state, input stage valid flag and queue pointers are cleared.
// ----------------------------------------------------------------------------
// Bus message deserializer
// Decodes a byte stream of bus messages into type, field, payload, end and empty-marker events.
// ----------------------------------------------------------------------------
`default_nettype none

module bus_message_deserializer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_kind,
  input  wire logic [7:0]                 in_data_in,
  input  wire logic                       in_end_of_message,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [2:0]                      out_event_res,
  output logic [3:0]                      out_msg_kind,
  output logic [7:0]                      out_type_byte,
  output logic [1:0]                      out_field_pos,
  output logic [bmd_pkg::VAL_W-1:0]       out_list_index,
  output logic [bmd_pkg::VAL_W-1:0]       out_value,
  output logic [7:0]                      out_data_out,
  output logic                            out_truncated,
  output logic                            out_run_last
);
  import bmd_pkg::*;

  logic              ir_v_r, ir_v_nxt;
  logic              ir_kind_r;
  logic [7:0]        ir_data_r;
  logic              ir_eom_r;
  logic              fire;
  res_t              dec0, dec1, head;
  logic [1:0]        dec_n;
  logic [QCNT_W-1:0] q_cnt;

  assign fire     = ir_v_r && (q_cnt <= QCNT_W'(QDEPTH - 2));
  assign in_stall = ir_v_r && !fire;
  assign ir_v_nxt = in_stall ? ir_v_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) ir_v_r <= 1'b0;
    else ir_v_r <= ir_v_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ir_kind_r <= in_kind;
      ir_data_r <= in_data_in;
      ir_eom_r  <= in_end_of_message;
    end
  end

  bmd_decoder u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .kind    (ir_kind_r),
    .data_in (ir_data_r),
    .eom     (ir_eom_r),
    .res0    (dec0),
    .res1    (dec1),
    .res_n   (dec_n)
  );

  bmd_out_queue u_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .push0  (dec0),
    .push1  (dec1),
    .push_n (dec_n),
    .pop    (out_valid && !out_stall),
    .head   (head),
    .count  (q_cnt)
  );

  assign out_valid      = (q_cnt != '0);
  assign out_event_res  = head.ev;
  assign out_msg_kind   = head.msg_kind;
  assign out_type_byte  = head.type_byte;
  assign out_field_pos  = head.field_pos;
  assign out_list_index = head.list_index;
  assign out_value      = head.value;
  assign out_data_out   = head.data_out;
  assign out_truncated  = head.truncated;
  assign out_run_last   = head.run_last;

`ifndef SYNTHESIS
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ir_v_r)
    else $error("input stalled with empty input stage");

  a_marker_out: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ir_kind_r) |=> out_valid)
    else $error("empty marker gave no result");

  a_eom_out: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ir_eom_r) |-> (dec_n != 2'd0))
    else $error("final byte gave no end record");
`endif

endmodule

`default_nettype wire

>>> src/bmd_decoder.sv
// ----------------------------------------------------------------------------
// Bus message deserializer decode stage
// Holds the message state and turns one byte into up to two result records.
// ----------------------------------------------------------------------------
`default_nettype none

module bmd_decoder (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire,
  input  wire logic           kind,
  input  wire logic [7:0]     data_in,
  input  wire logic           eom,
  output bmd_pkg::res_t       res0,
  output bmd_pkg::res_t       res1,
  output logic [1:0]          res_n
);
  import bmd_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic [3:0]         kind_r, kind_nxt;
  logic [7:0]         type_r, type_nxt;
  logic [1:0]         sp_r, sp_nxt;
  logic [VAL_W-1:0]   acc_r, acc_nxt;
  logic [2:0]         xl_r, xl_nxt;
  logic [VAL_W-1:0]   sl_r, sl_nxt;
  logic [VAL_W-1:0]   ll_r, ll_nxt;
  logic [VAL_W-1:0]   lp_r, lp_nxt;
  res_t               raw0, raw1;
  logic [1:0]         raw_n;

  // next state and raw records
  always_comb begin
    phase_t           ph;
    logic [3:0]       kh;
    logic [7:0]       th;
    logic [1:0]       sp;
    logic [VAL_W-1:0] acc, sl, ll, lp, v, li;
    logic [2:0]       xl;
    logic [7:0]       negb;
    logic             num_done, do_adv, trunc;
    logic [1:0]       n;
    res_t             e0, e1, r;

    ph = phase_r; kh = kind_r; th = type_r; sp = sp_r; acc = acc_r;
    xl = xl_r; sl = sl_r; ll = ll_r; lp = lp_r;
    num_done = 1'b0; do_adv = 1'b0; trunc = 1'b0;
    n = 2'd0;
    e0 = make_res(EV_EMPTY, 4'd0, 8'd0, 2'd0, '0, '0, 8'd0, 1'b0);
    e1 = e0;
    r  = e0;
    negb = 8'd0 - data_in;
    v  = '0;
    li = '0;

    if (kind) begin
      ph = PH_TYPE; kh = '0; th = '0; sp = '0; acc = '0;
      xl = '0; sl = '0; ll = '0; lp = '0;
      e0 = make_res(EV_EMPTY, 4'd0, 8'd0, 2'd0, '0, '0, 8'd0, 1'b0);
      n = 2'd1;
    end else begin
      unique case (phase_r)
        PH_TYPE: begin
          sp = '0; acc = '0; xl = '0; sl = '0; ll = '0; lp = '0;
          th = data_in;
          kh = (data_in >= KNOWN_LOW) ? negb[3:0] : KIND_USER;
          e0 = make_res(EV_TYPE, kh, th, 2'd0, '0, '0, 8'd0, 1'b0);
          n = 2'd1;
          if (kh == KIND_USER) ph = PH_PAYLOAD;
          else ph = enter_phase(kh, sp, ll);
        end
        PH_NUM_HEAD: begin
          xl = data_in[7:5];
          acc = VAL_W'(data_in & HEAD_VALUE_MASK);
          if (xl == 3'd0) num_done = 1'b1;
          else ph = PH_NUM_EXTRA;
        end
        PH_NUM_EXTRA: begin
          acc = {acc_r[VAL_W-9:0], data_in};
          xl = xl_r - 3'd1;
          if (xl == 3'd0) num_done = 1'b1;
        end
        PH_STR: begin
          li = (is_list(kh) && (sp == 2'd1)) ? lp : '0;
          e0 = make_res(EV_STR_BYTE, kh, th, sp, li, '0, data_in, 1'b0);
          n = 2'd1;
          sl = sl_r - VAL_W'(1);
          if (sl == '0) do_adv = 1'b1;
        end
        PH_PAYLOAD: begin
          e0 = make_res(EV_PAYLOAD, kh, th, 2'd0, '0, '0, data_in, 1'b0);
          n = 2'd1;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (num_done) begin
        v = acc;
        n = 2'd1;
        if (field_is_string(kh, sp)) begin
          li = (is_list(kh) && (sp == 2'd1)) ? lp : '0;
          e0 = make_res(EV_STR_HDR, kh, th, sp, li, v, 8'd0, 1'b0);
          sl = v;
          if (v == '0) do_adv = 1'b1;
          else ph = PH_STR;
        end else begin
          e0 = make_res(EV_UINT, kh, th, sp, '0, v, 8'd0, 1'b0);
          if (is_list(kh) && (sp == 2'd0)) begin
            ll = v;
            lp = '0;
          end
          do_adv = 1'b1;
        end
      end

      if (do_adv) begin
        if (is_list(kh)) begin
          if (sp == 2'd0) begin
            sp = 2'd1;
          end else begin
            ll = ll - VAL_W'(1);
            lp = lp + VAL_W'(1);
          end
          ph = enter_phase(kh, sp, ll);
        end else if (({1'b0, sp} + 3'd1) >= field_count(kh)) begin
          ph = PH_DONE;
        end else begin
          sp = sp + 2'd1;
          ph = enter_phase(kh, sp, ll);
        end
      end

      if (eom) begin
        trunc = (ph == PH_NUM_HEAD) || (ph == PH_NUM_EXTRA) || (ph == PH_STR);
        if (ph == PH_NUM_EXTRA) begin
          li = (is_list(kh) && (sp == 2'd1)) ? lp : '0;
          r = make_res(field_is_string(kh, sp) ? EV_STR_HDR : EV_UINT,
                       kh, th, sp, li, acc, 8'd0, 1'b0);
          if (n == 2'd0) e0 = r;
          else e1 = r;
          n = n + 2'd1;
        end
        r = make_res(EV_END, kh, th, 2'd0, '0, '0, 8'd0, trunc);
        if (n == 2'd0) e0 = r;
        else e1 = r;
        n = n + 2'd1;
        ph = PH_TYPE; kh = '0; th = '0; sp = '0; acc = '0;
        xl = '0; sl = '0; ll = '0; lp = '0;
      end
    end

    phase_nxt = ph; kind_nxt = kh; type_nxt = th; sp_nxt = sp; acc_nxt = acc;
    xl_nxt = xl; sl_nxt = sl; ll_nxt = ll; lp_nxt = lp;
    raw0 = e0; raw1 = e1; raw_n = n;
  end

  // result records with last-of-transfer marking
  always_comb begin
    res0 = raw0;
    res1 = raw1;
    res_n = fire ? raw_n : 2'd0;
    res0.run_last = (raw_n == 2'd1);
    res1.run_last = (raw_n == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      kind_r  <= '0;
      type_r  <= '0;
      sp_r    <= '0;
      acc_r   <= '0;
      xl_r    <= '0;
      sl_r    <= '0;
      ll_r    <= '0;
      lp_r    <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      type_r  <= type_nxt;
      sp_r    <= sp_nxt;
      acc_r   <= acc_nxt;
      xl_r    <= xl_nxt;
      sl_r    <= sl_nxt;
      ll_r    <= ll_nxt;
      lp_r    <= lp_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/bmd_out_queue.sv
// ----------------------------------------------------------------------------
// Bus message deserializer result queue
// Small queue taking up to two records per cycle and releasing at most one.
// ----------------------------------------------------------------------------
`default_nettype none

module bmd_out_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire bmd_pkg::res_t          push0,
  input  wire bmd_pkg::res_t          push1,
  input  wire logic [1:0]             push_n,
  input  wire logic                   pop,
  output bmd_pkg::res_t               head,
  output logic [bmd_pkg::QCNT_W-1:0]  count
);
  import bmd_pkg::*;

  res_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic [QPTR_W-1:0] wr_plus1;

  assign wr_plus1 = wr_r + QPTR_W'(1);
  assign head     = mem_r[rd_r];
  assign count    = cnt_r;

  always_comb begin
    wr_nxt  = wr_r + QPTR_W'(push_n);
    rd_nxt  = rd_r + QPTR_W'(pop);
    cnt_nxt = cnt_r + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_r] <= push0;
    if (push_n == 2'd2) mem_r[wr_plus1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

>>> bench/bus_message_deserializer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bus message deserializer testbench
// Feeds well-formed, cut short, interrupted and noisy bus messages through the
// deserializer under several pacing mixes. A scoreboard decodes each transfer
// itself and checks every emitted token event, field by field, in order.
// ----------------------------------------------------------------------------

import bmd_pkg::*;

class token_tracker;
  phase_t      ph;
  logic [3:0]  kind;
  logic [7:0]  code;
  logic [1:0]  pos;
  logic [60:0] accum;
  logic [2:0]  extra_left;
  logic [60:0] str_left;
  logic [60:0] list_left;
  logic [60:0] list_pos;
  res_t        pending_tokens[$];
  int unsigned mismatches;
  int unsigned tokens_checked;
  int unsigned truncated_ends;
  int unsigned empty_markers;

  function new();
    clear();
    mismatches = 0;
    tokens_checked = 0;
    truncated_ends = 0;
    empty_markers = 0;
  endfunction

  function void clear();
    ph = PH_TYPE;
    kind = KIND_USER;
    code = 8'd0;
    pos = 2'd0;
    accum = '0;
    extra_left = 3'd0;
    str_left = '0;
    list_left = '0;
    list_pos = '0;
  endfunction

  function int fields_in_kind(input logic [3:0] k);
    if (k == KIND_MESSAGE) return 4;
    if (channel_list(k)) return 2;
    if (k == KIND_NOROUTE || k == KIND_ADD_GROUP) return 2;
    if (k >= KIND_CLOSE_GROUP && k <= KIND_SERIAL) return 1;
    return 0;
  endfunction

  function bit channel_list(input logic [3:0] k);
    return (k >= KIND_REPLACE) && (k <= KIND_ERASE);
  endfunction

  function bit string_field(input logic [3:0] k, input logic [1:0] p);
    if (k == KIND_MESSAGE) return p != 2'd0;
    if (channel_list(k)) return p == 2'd1;
    return k != KIND_NEW_SESSION;
  endfunction

  function logic [60:0] list_slot();
    return (channel_list(kind) && pos == 2'd1) ? list_pos : '0;
  endfunction

  function void push_token(input event_t ev, input logic [1:0] fpos,
                           input logic [60:0] lidx, input logic [60:0] val,
                           input logic [7:0] dout, input logic trunc);
    res_t r;
    r.ev = ev;
    r.msg_kind = (ev == EV_EMPTY) ? 4'd0 : kind;
    r.type_byte = (ev == EV_EMPTY) ? 8'd0 : code;
    r.field_pos = fpos;
    r.list_index = lidx;
    r.value = val;
    r.data_out = dout;
    r.truncated = trunc;
    r.run_last = 1'b0;
    pending_tokens.push_back(r);
  endfunction

  function void open_field();
    if (fields_in_kind(kind) == 0) ph = PH_DONE;
    else if (channel_list(kind) && pos == 2'd1 && list_left == '0) ph = PH_DONE;
    else ph = PH_NUM_HEAD;
  endfunction

  function void next_field();
    if (channel_list(kind)) begin
      if (pos == 2'd0) begin
        pos = 2'd1;
      end else begin
        list_left = list_left - 61'd1;
        list_pos = list_pos + 61'd1;
      end
      open_field();
    end else if (int'(pos) + 1 >= fields_in_kind(kind)) begin
      ph = PH_DONE;
    end else begin
      pos = pos + 2'd1;
      open_field();
    end
  endfunction

  function void close_number();
    if (string_field(kind, pos)) begin
      push_token(EV_STR_HDR, pos, list_slot(), accum, 8'd0, 1'b0);
      str_left = accum;
      if (accum == '0) next_field();
      else ph = PH_STR;
    end else begin
      push_token(EV_UINT, pos, '0, accum, 8'd0, 1'b0);
      if (channel_list(kind) && pos == 2'd0) begin
        list_left = accum;
        list_pos = '0;
      end
      next_field();
    end
  endfunction

  function void note_transfer(input logic marker, input logic [7:0] b, input logic eom);
    int   first;
    logic trunc;
    first = pending_tokens.size();
    if (marker) begin
      clear();
      push_token(EV_EMPTY, 2'd0, '0, '0, 8'd0, 1'b0);
      empty_markers++;
    end else begin
      case (ph)
        PH_TYPE: begin
          clear();
          code = b;
          kind = (b >= KNOWN_LOW) ? 4'(9'h100 - {1'b0, b}) : KIND_USER;
          push_token(EV_TYPE, 2'd0, '0, '0, 8'd0, 1'b0);
          if (kind == KIND_USER) ph = PH_PAYLOAD;
          else open_field();
        end
        PH_NUM_HEAD: begin
          extra_left = b[7:5];
          accum = {56'd0, b[4:0]};
          if (extra_left == 3'd0) close_number();
          else ph = PH_NUM_EXTRA;
        end
        PH_NUM_EXTRA: begin
          accum = {accum[52:0], b};
          extra_left = extra_left - 3'd1;
          if (extra_left == 3'd0) close_number();
        end
        PH_STR: begin
          push_token(EV_STR_BYTE, pos, list_slot(), '0, b, 1'b0);
          str_left = str_left - 61'd1;
          if (str_left == '0) next_field();
        end
        PH_PAYLOAD: push_token(EV_PAYLOAD, 2'd0, '0, '0, b, 1'b0);
        default: ;
      endcase
      if (eom) begin
        trunc = (ph == PH_NUM_HEAD) || (ph == PH_NUM_EXTRA) || (ph == PH_STR);
        // partial number read so far still goes out before the end token
        if (ph == PH_NUM_EXTRA)
          push_token(string_field(kind, pos) ? EV_STR_HDR : EV_UINT, pos, list_slot(),
                     accum, 8'd0, 1'b0);
        push_token(EV_END, 2'd0, '0, '0, 8'd0, trunc);
        if (trunc) truncated_ends++;
        clear();
      end
    end
    if (pending_tokens.size() > first)
      pending_tokens[pending_tokens.size() - 1].run_last = 1'b1;
  endfunction

  function string describe(input res_t r);
    return $sformatf("ev=%0d kind=%0d type=%02h pos=%0d idx=%0h val=%0h data=%02h trunc=%0b last=%0b",
                     r.ev, r.msg_kind, r.type_byte, r.field_pos, r.list_index, r.value,
                     r.data_out, r.truncated, r.run_last);
  endfunction

  function void check_token(input res_t got);
    res_t want;
    bit   bad;
    tokens_checked++;
    if (pending_tokens.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected token, none pending: %s", describe(got));
      return;
    end
    want = pending_tokens.pop_front();
    bad = (got.ev !== want.ev) || (got.msg_kind !== want.msg_kind) ||
          (got.type_byte !== want.type_byte) || (got.field_pos !== want.field_pos) ||
          (got.list_index !== want.list_index) || (got.value !== want.value) ||
          (got.data_out !== want.data_out) || (got.truncated !== want.truncated) ||
          (got.run_last !== want.run_last);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("token mismatch %0d", mismatches);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endfunction
endclass

module bus_message_deserializer_tb;

  localparam logic [7:0] CODE_MESSAGE     = 8'hFF;
  localparam logic [7:0] CODE_REPLACE     = 8'hFE;
  localparam logic [7:0] CODE_ADD         = 8'hFD;
  localparam logic [7:0] CODE_ERASE       = 8'hFC;
  localparam logic [7:0] CODE_RESET       = 8'hFB;
  localparam logic [7:0] CODE_NOROUTE     = 8'hFA;
  localparam logic [7:0] CODE_ADD_GROUP   = 8'hF9;
  localparam logic [7:0] CODE_CLOSE_GROUP = 8'hF8;
  localparam logic [7:0] CODE_GROUP_EMPTY = 8'hF7;
  localparam logic [7:0] CODE_NEW_SESSION = 8'hF6;
  localparam logic [7:0] CODE_SERIAL      = 8'hF5;

  localparam int unsigned BYTES_PER_PHASE = 488;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned SETTLE_CYCLES   = 8;

  logic              clk;
  logic              rst_n             = 1'b0;
  logic              in_valid          = 1'b0;
  logic              in_kind           = 1'b0;
  logic [7:0]        in_data_in        = 8'd0;
  logic              in_end_of_message = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall         = 1'b0;
  logic [2:0]        out_event_res;
  logic [3:0]        out_msg_kind;
  logic [7:0]        out_type_byte;
  logic [1:0]        out_field_pos;
  logic [VAL_W-1:0]  out_list_index;
  logic [VAL_W-1:0]  out_value;
  logic [7:0]        out_data_out;
  logic              out_truncated;
  logic              out_run_last;

  token_tracker tracker;
  int unsigned  idle_pct     = 0;
  int unsigned  stall_pct    = 0;
  int unsigned  bytes_sent   = 0;
  int unsigned  messages_sent = 0;
  int unsigned  quiet_cycles = 0;
  logic [7:0]   msg_bytes[$];
  int unsigned  idle_plan[4]  = '{0, 81, 0, 34};
  int unsigned  stall_plan[4] = '{0, 0, 81, 34};

  bus_message_deserializer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_data_in        (in_data_in),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_msg_kind      (out_msg_kind),
    .out_type_byte     (out_type_byte),
    .out_field_pos     (out_field_pos),
    .out_list_index    (out_list_index),
    .out_value         (out_value),
    .out_data_out      (out_data_out),
    .out_truncated     (out_truncated),
    .out_run_last      (out_run_last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : token_monitor
    res_t got;
    got.ev = event_t'(out_event_res);
    got.msg_kind = out_msg_kind;
    got.type_byte = out_type_byte;
    got.field_pos = out_field_pos;
    got.list_index = out_list_index;
    got.value = out_value;
    got.data_out = out_data_out;
    got.truncated = out_truncated;
    got.run_last = out_run_last;
    if (rst_n && out_valid && !out_stall) tracker.check_token(got);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic marker, input logic [7:0] b, input logic eom);
    while ((idle_pct != 0) && ($urandom_range(0, 99) < idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= marker;
    in_data_in <= b;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_transfer(marker, b, eom);
    bytes_sent++;
  endtask

  task automatic send_marker();
    send_byte(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_message(input logic with_end);
    foreach (msg_bytes[i])
      send_byte(1'b0, msg_bytes[i], with_end && (i == msg_bytes.size() - 1));
    messages_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending_tokens.size() != 0) @(posedge clk);
  endtask

  // head byte carries the extra-byte count and the top five value bits
  function automatic void put_uint(input logic [60:0] v, input int unsigned extra);
    logic [63:0] w;
    w = {3'd0, v} >> (8 * extra);
    msg_bytes.push_back({3'(extra), w[4:0]});
    for (int i = int'(extra) - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_random_uint();
    logic [63:0] r;
    r = {$urandom, $urandom};
    put_uint(r[60:0], ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 7));
  endfunction

  function automatic void put_string();
    logic [63:0] r;
    int unsigned len;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 29) == 0) begin
      // announced length far beyond the end of the message
      put_uint({1'b1, r[59:0]}, 7);
      repeat ($urandom_range(0, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(0, 5);
      put_uint(61'(len), ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0);
      repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void build_known(input logic [7:0] code);
    int unsigned count;
    case (code)
      CODE_MESSAGE: begin
        put_random_uint();
        repeat (3) put_string();
      end
      CODE_REPLACE, CODE_ADD, CODE_ERASE: begin
        if ($urandom_range(0, 19) == 0) begin
          put_random_uint();
          repeat ($urandom_range(0, 2)) put_string();
        end else begin
          count = $urandom_range(0, 3);
          put_uint(61'(count), $urandom_range(0, 1));
          repeat (count) put_string();
        end
      end
      CODE_RESET: ;
      CODE_NOROUTE, CODE_ADD_GROUP: repeat (2) put_string();
      CODE_NEW_SESSION: put_random_uint();
      default: put_string();
    endcase
  endfunction

  task automatic send_random_message();
    int unsigned shape;
    int unsigned cut;
    logic [7:0]  code;
    msg_bytes.delete();
    shape = $urandom_range(0, 99);
    if (shape < 4) begin
      send_marker();
      return;
    end
    if (shape < 12) begin
      msg_bytes.push_back(8'($urandom_range(0, int'(KNOWN_LOW) - 1)));
      repeat ($urandom_range(0, 6)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (shape < 20) begin
      repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      code = 8'($urandom_range(int'(KNOWN_LOW), 255));
      msg_bytes.push_back(code);
      build_known(code);
      if (shape < 30) begin
        cut = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end else if (shape < 36) begin
        repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (shape < 40) begin
        // abandoned part way by an empty marker
        cut = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
        send_message(1'b0);
        send_marker();
        return;
      end
    end
    send_message(1'b1);
  endtask

  initial begin
    int unsigned phase_start;
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    msg_bytes = '{8'h00, 8'hFF};
    send_message(1'b1);
    msg_bytes = '{8'hF4, 8'h00};
    send_message(1'b1);
    msg_bytes = '{CODE_MESSAGE, 8'h00, 8'h00, 8'h01, 8'h5A, 8'h00};
    send_message(1'b1);
    msg_bytes = '{CODE_REPLACE, 8'h00};
    send_message(1'b1);
    msg_bytes = '{CODE_ADD, 8'h02, 8'h01, 8'h41};
    send_message(1'b1);
    msg_bytes = '{CODE_ERASE, 8'hE3, 8'h80};
    send_message(1'b1);
    msg_bytes = '{CODE_RESET, 8'h7E};
    send_message(1'b1);
    msg_bytes = '{CODE_NOROUTE, 8'h00};
    send_message(1'b1);
    msg_bytes = '{CODE_ADD_GROUP};
    send_message(1'b1);
    msg_bytes = '{CODE_CLOSE_GROUP};
    send_message(1'b1);
    msg_bytes = '{CODE_GROUP_EMPTY};
    send_message(1'b1);
    msg_bytes = '{CODE_NEW_SESSION, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_message(1'b1);
    msg_bytes = '{CODE_SERIAL, 8'h03, 8'h41};
    send_message(1'b0);
    send_marker();
    send_marker();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      stall_pct = stall_plan[p];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < BYTES_PER_PHASE) send_random_message();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d byte transfers in %0d messages; %0d token events checked.",
             bytes_sent, messages_sent, tracker.tokens_checked);
    $display("Run included %0d truncated endings and %0d empty markers over four pacing mixes.",
             tracker.truncated_ends, tracker.empty_markers);
    if (tracker.mismatches == 0 && tracker.pending_tokens.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
